>>> rtl/p80_pkg.sv
`timescale 1ns / 1ps

package p80_pkg;

    // Round count and field widths
    localparam int ROUNDS     = 31;
    localparam int BLK_W      = 64;
    localparam int KEY_W      = 80;
    localparam int KEY_LO_W   = 16;
    localparam int RC_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER = 2'd1;

    typedef logic [BLK_W-1:0] t_block;
    typedef logic [KEY_W-1:0] t_key;

    // 4-bit S-box
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    // S-box on all 16 nibbles
    function automatic t_block sub_layer(input t_block s);
        t_block r;
        for (int n = 0; n < BLK_W / 4; n++) begin
            r[n*4 +: 4] = sbox(s[n*4 +: 4]);
        end
        return r;
    endfunction

    // Bit j goes to j*16 mod 63, bit 63 stays put
    function automatic t_block perm_layer(input t_block s);
        t_block r;
        for (int j = 0; j < BLK_W; j++) begin
            if (j == BLK_W - 1) begin
                r[j] = s[j];
            end else begin
                r[(j * 16) % (BLK_W - 1)] = s[j];
            end
        end
        return r;
    endfunction

    // Round key is the top 64 bits of the key register
    function automatic t_block round_key(input t_key k);
        return k[KEY_W-1 -: BLK_W];
    endfunction

    // Key schedule step: rotate left 61, S-box top nibble, counter into 19..15
    function automatic t_key key_update(input t_key k, input logic [RC_W-1:0] rc);
        t_key r;
        r = {k[18:0], k[KEY_W-1:19]};
        r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
        r[19:15] = r[19:15] ^ rc;
        return r;
    endfunction

endpackage

>>> rtl/present80_block_encrypt.sv
`timescale 1ns / 1ps
// PRESENT-80 encryption pipeline.
//
// Input channel: i_valid / o_stall carry one 64-bit plaintext word; a word is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry the 64-bit ciphertext word; it is
// taken at a rising edge with o_valid high and i_stall low.
// Key: written through i_cfg_we / i_cfg_index / i_cfg_data (index 0 = key
// bits 79..16, index 1 = key bits 15..0). The key is captured with each
// word, so it must only change while the pipeline is empty.
// A word passes one capture stage plus one stage per round, the last also
// doing the whitening XOR. Throughput: one word per cycle when not stalled;
// each of the 31 round stages holds one word.
// Reset (synchronous, active low) clears all stage valid bits and sets the
// key to zero; words in flight are dropped.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// o_stall rises, so nothing is lost or repeated.
module present80_block_encrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input word
    input  logic                           i_valid,
    output logic                           o_stall,
    input  p80_pkg::t_block                i_plaintext,
    // output word
    output logic                           o_valid,
    input  logic                           i_stall,
    output p80_pkg::t_block                o_ciphertext,
    // key writes
    input  logic                           i_cfg_we,
    input  logic [p80_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [p80_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import p80_pkg::*;

    logic [BLK_W-1:0]    r_key_upper;
    logic [KEY_LO_W-1:0] r_key_lower;

    logic   r_vld   [0:ROUNDS];
    t_block r_state [0:ROUNDS];
    t_key   r_key   [0:ROUNDS-1];

    logic en;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_KEY_UPPER) begin
                r_key_upper <= i_cfg_data;
            end else if (i_cfg_index == CFG_KEY_LOWER) begin
                r_key_lower <= i_cfg_data[KEY_LO_W-1:0];
            end
        end
    end

    // Whole pipeline holds while the output word is stalled
    assign en      = !(r_vld[ROUNDS] && i_stall);
    assign o_stall = !en;

    // Capture stage: plaintext plus the key in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_state[0] <= i_plaintext;
            r_key[0]   <= {r_key_upper, r_key_lower};
        end
    end

    // One round per stage
    for (genvar k = 1; k <= ROUNDS; k++) begin : g_round
        t_block n_state;
        t_key   n_key;

        always_comb begin
            n_key   = key_update(r_key[k-1], RC_W'(k));
            n_state = perm_layer(sub_layer(r_state[k-1] ^ round_key(r_key[k-1])));
            // last round adds the whitening key
            if (k == ROUNDS) begin
                n_state = n_state ^ round_key(n_key);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_state[k] <= n_state;
            end
        end

        // key travels on to the next round; the last round has no successor
        if (k < ROUNDS) begin : g_key
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_key[k] <= n_key;
                end
            end
        end
    end

    assign o_valid      = r_vld[ROUNDS];
    assign o_ciphertext = r_state[ROUNDS];

    // Checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word waiting");

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word not captured");

    a_valid_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && en) |=> (r_vld[1] == $past(r_vld[0])))
        else $error("valid bit lost or invented between stages");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !en) |=> (r_vld[0] == $past(r_vld[0]) && $stable(r_state[0])))
        else $error("capture stage changed while pipeline held");

    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cfg_we && i_cfg_index == CFG_KEY_UPPER)
        |=> (r_key_upper == $past(i_cfg_data)))
        else $error("key upper write not taken");

endmodule
